// File: rtl/hre_pkg.sv
`default_nettype none
package hre_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CW = 32;
  localparam int SW = 66;
  localparam int QB = 34;
  localparam int AW = SW + FRAC_BITS + 1;
  localparam int EW = 64;
  localparam int RIW = 3;

  localparam logic [RIW-1:0] REG_ROW0_AB = 3'd0;
  localparam logic [RIW-1:0] REG_ROW0_C  = 3'd1;
  localparam logic [RIW-1:0] REG_ROW1_AB = 3'd2;
  localparam logic [RIW-1:0] REG_ROW1_C  = 3'd3;
  localparam logic [RIW-1:0] REG_ROW2_AB = 3'd4;
  localparam logic [RIW-1:0] REG_ROW2_C  = 3'd5;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] w;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
  } sum_t;

  typedef struct packed {
    logic [SW-1:0] rx;
    logic [SW-1:0] ry;
    logic [QB-1:0] ax;
    logic [QB-1:0] ay;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic [SW-1:0] d;
    logic nx;
    logic ny;
    logic ovx;
    logic ovy;
    logic wz;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
  } div_t;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] r;
    r = v[SW-1] ? SW'(-v) : SW'(v);
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/hre_mac.sv
`default_nettype none
module hre_mac (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic v_i,
  input  wire logic signed [hre_pkg::CW-1:0] sx,
  input  wire logic signed [hre_pkg::CW-1:0] sy,
  input  wire logic signed [hre_pkg::CW-1:0] dx,
  input  wire logic signed [hre_pkg::CW-1:0] dy,
  input  wire logic [63:0] r0ab,
  input  wire logic [63:0] r1ab,
  input  wire logic [63:0] r2ab,
  input  wire logic signed [hre_pkg::CW-1:0] r0c,
  input  wire logic signed [hre_pkg::CW-1:0] r1c,
  input  wire logic signed [hre_pkg::CW-1:0] r2c,
  output logic v_o,
  output hre_pkg::sum_t s_o
);
  localparam int F = hre_pkg::FRAC_BITS;
  localparam int SW = hre_pkg::SW;
  localparam int CW = hre_pkg::CW;

  logic signed [63:0] p_r [6];
  logic signed [CW-1:0] c_r [3];
  logic signed [CW-1:0] dx_r, dy_r;
  logic v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
    end
    if (en) begin
      p_r[0] <= signed'(r0ab[31:0])  * sx;
      p_r[1] <= signed'(r0ab[63:32]) * sy;
      p_r[2] <= signed'(r1ab[31:0])  * sx;
      p_r[3] <= signed'(r1ab[63:32]) * sy;
      p_r[4] <= signed'(r2ab[31:0])  * sx;
      p_r[5] <= signed'(r2ab[63:32]) * sy;
      c_r[0] <= r0c;
      c_r[1] <= r1c;
      c_r[2] <= r2c;
      dx_r <= dx;
      dy_r <= dy;
    end
  end

  function automatic logic signed [SW-1:0] dot(input logic signed [63:0] a,
      input logic signed [63:0] b, input logic signed [CW-1:0] c);
    logic signed [SW-1:0] ea, eb, ec;
    ea = {{(SW-64){a[63]}}, a};
    eb = {{(SW-64){b[63]}}, b};
    ec = {{(SW-CW-F){c[CW-1]}}, c, {F{1'b0}}};
    return ea + eb + ec;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v1_r;
    end
    if (en) begin
      s_o.x  <= dot(p_r[0], p_r[1], c_r[0]);
      s_o.y  <= dot(p_r[2], p_r[3], c_r[1]);
      s_o.w  <= dot(p_r[4], p_r[5], c_r[2]);
      s_o.dx <= dx_r;
      s_o.dy <= dy_r;
    end
  end
endmodule
`default_nettype wire

// File: rtl/hre_div_step.sv
`default_nettype none
module hre_div_step (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic v_i,
  input  wire hre_pkg::div_t d_i,
  output logic v_o,
  output hre_pkg::div_t d_o
);
  localparam int SW = hre_pkg::SW;
  localparam int QB = hre_pkg::QB;

  logic [SW:0] tx, ty;
  logic gx, gy;
  hre_pkg::div_t nxt;

  always_comb begin
    tx = {d_i.rx, d_i.ax[QB-1]};
    ty = {d_i.ry, d_i.ay[QB-1]};
    gx = tx >= {1'b0, d_i.d};
    gy = ty >= {1'b0, d_i.d};
    nxt = d_i;
    nxt.rx = gx ? SW'(tx - {1'b0, d_i.d}) : tx[SW-1:0];
    nxt.ry = gy ? SW'(ty - {1'b0, d_i.d}) : ty[SW-1:0];
    nxt.ax = {d_i.ax[QB-2:0], 1'b0};
    nxt.ay = {d_i.ay[QB-2:0], 1'b0};
    nxt.qx = {d_i.qx[QB-2:0], gx};
    nxt.qy = {d_i.qy[QB-2:0], gy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
    if (en) begin
      d_o <= nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/hre_div.sv
`default_nettype none
module hre_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic v_i,
  input  wire hre_pkg::sum_t s_i,
  output logic v_o,
  output hre_pkg::div_t d_o
);
  localparam int SW = hre_pkg::SW;
  localparam int QB = hre_pkg::QB;
  localparam int AW = hre_pkg::AW;
  localparam int F = hre_pkg::FRAC_BITS;

  logic [SW-1:0] mx, my, mw;
  logic [AW-1:0] axw, ayw;
  logic [SW-1:0] hx, hy;
  hre_pkg::div_t prep;
  hre_pkg::div_t st [QB+1];
  logic vs [QB+1];

  always_comb begin
    mx = hre_pkg::mag(s_i.x);
    my = hre_pkg::mag(s_i.y);
    mw = hre_pkg::mag(s_i.w);
    axw = {mx, {(F+1){1'b0}}};
    ayw = {my, {(F+1){1'b0}}};
    hx = SW'(axw[AW-1:QB]);
    hy = SW'(ayw[AW-1:QB]);
    prep.rx = hx;
    prep.ry = hy;
    prep.ax = axw[QB-1:0];
    prep.ay = ayw[QB-1:0];
    prep.qx = '0;
    prep.qy = '0;
    prep.d = mw;
    prep.nx = s_i.x[SW-1] ^ s_i.w[SW-1];
    prep.ny = s_i.y[SW-1] ^ s_i.w[SW-1];
    prep.ovx = hx >= mw;
    prep.ovy = hy >= mw;
    prep.wz = (mw == '0);
    prep.dx = s_i.dx;
    prep.dy = s_i.dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= v_i;
    end
    if (en) begin
      st[0] <= prep;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    hre_div_step u_step (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_i(vs[i]), .d_i(st[i]), .v_o(vs[i+1]), .d_o(st[i+1])
    );
  end

  assign v_o = vs[QB];
  assign d_o = st[QB];
endmodule
`default_nettype wire

// File: rtl/hre_err.sv
`default_nettype none
module hre_err (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic v_i,
  input  wire hre_pkg::div_t d_i,
  output logic v_o,
  output logic signed [hre_pkg::CW-1:0] px_o,
  output logic signed [hre_pkg::CW-1:0] py_o,
  output logic [hre_pkg::EW-1:0] err_o,
  output logic wz_o
);
  localparam int QB = hre_pkg::QB;
  localparam int CW = hre_pkg::CW;
  localparam int EW = hre_pkg::EW;

  function automatic logic [CW-1:0] proj(input logic [QB-1:0] q2, input logic neg,
      input logic ov, input logic wz);
    logic [QB:0] t;
    logic [QB-1:0] q;
    logic [CW-1:0] r;
    t = {1'b0, q2} + (QB+1)'(1);
    q = t[QB:1];
    if (wz) begin
      r = '0;
    end else if (!neg) begin
      r = (ov || (|q[QB-1:CW-1])) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
    end else begin
      if (ov || (|q[QB-1:CW]) || (q[CW-1] && (|q[CW-2:0]))) begin
        r = {1'b1, {(CW-1){1'b0}}};
      end else begin
        r = CW'(-q[CW-1:0]);
      end
    end
    return r;
  endfunction

  logic v1_r, v2_r, v3_r;
  logic wz1_r, wz2_r, wz3_r;
  logic signed [CW-1:0] px1_r, py1_r, dx1_r, dy1_r;
  logic signed [CW-1:0] px2_r, py2_r, px3_r, py3_r;
  logic [CW:0] ax2_r, ay2_r;
  logic [2*CW+1:0] sx3_r, sy3_r;
  logic signed [CW:0] ex, ey;
  logic [2*CW+2:0] tot;

  always_comb begin
    ex = {dx1_r[CW-1], dx1_r} - {px1_r[CW-1], px1_r};
    ey = {dy1_r[CW-1], dy1_r} - {py1_r[CW-1], py1_r};
    tot = {1'b0, sx3_r} + {1'b0, sy3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v_o  <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v_o  <= v3_r;
    end
    if (en) begin
      // round, saturate
      px1_r <= proj(d_i.qx, d_i.nx, d_i.ovx, d_i.wz);
      py1_r <= proj(d_i.qy, d_i.ny, d_i.ovy, d_i.wz);
      dx1_r <= d_i.dx;
      dy1_r <= d_i.dy;
      wz1_r <= d_i.wz;
      // distance magnitude
      ax2_r <= ex[CW] ? (CW+1)'(-ex) : (CW+1)'(ex);
      ay2_r <= ey[CW] ? (CW+1)'(-ey) : (CW+1)'(ey);
      px2_r <= px1_r;
      py2_r <= py1_r;
      wz2_r <= wz1_r;
      // squares
      sx3_r <= ax2_r * ax2_r;
      sy3_r <= ay2_r * ay2_r;
      px3_r <= px2_r;
      py3_r <= py2_r;
      wz3_r <= wz2_r;
      // sum, saturate
      px_o <= px3_r;
      py_o <= py3_r;
      wz_o <= wz3_r;
      err_o <= (wz3_r || (|tot[2*CW+2:EW])) ? {EW{1'b1}} : tot[EW-1:0];
    end
  end
endmodule
`default_nettype wire

// File: rtl/homography_reprojection_error.sv
// Homography reprojection error, fully pipelined.
// Pipeline: 2 multiply/sum stages, 1 divider setup stage,
// 34 divider bit stages, 4 round/error stages.
// Throughput: one beat per cycle; the whole pipe holds while out_valid waits on out_ready.
// Reset (rst_n low, synchronous): pipe emptied, H set to identity.
`default_nettype none
module homography_reprojection_error (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [31:0] in_src_x,
  input  wire logic signed [31:0] in_src_y,
  input  wire logic signed [31:0] in_dst_x,
  input  wire logic signed [31:0] in_dst_y,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [31:0] out_proj_x,
  output logic signed [31:0] out_proj_y,
  output logic [63:0] out_sq_error,
  output logic out_w_zero,
  input  wire logic cfg_we,
  input  wire logic [hre_pkg::RIW-1:0] cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int F = hre_pkg::FRAC_BITS;
  localparam int CW = hre_pkg::CW;

  // Matrix registers; packed rows hold the a coefficient low, b high.
  logic [63:0] r0ab_r, r1ab_r, r2ab_r;
  logic signed [CW-1:0] r0c_r, r1c_r, r2c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0ab_r <= 64'(1) << F;
      r0c_r  <= '0;
      r1ab_r <= (64'(1) << F) << 32;
      r1c_r  <= '0;
      r2ab_r <= '0;
      r2c_r  <= CW'(1) << F;
    end else if (cfg_we) begin
      case (cfg_index)
        hre_pkg::REG_ROW0_AB: r0ab_r <= cfg_data;
        hre_pkg::REG_ROW0_C:  r0c_r  <= cfg_data[CW-1:0];
        hre_pkg::REG_ROW1_AB: r1ab_r <= cfg_data;
        hre_pkg::REG_ROW1_C:  r1c_r  <= cfg_data[CW-1:0];
        hre_pkg::REG_ROW2_AB: r2ab_r <= cfg_data;
        hre_pkg::REG_ROW2_C:  r2c_r  <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Single pipe enable: advance unless the output register holds an untaken beat.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic v_mac;
  hre_pkg::sum_t s_mac;
  logic v_div;
  hre_pkg::div_t d_div;

  hre_mac u_mac (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(in_valid && in_ready),
    .sx(in_src_x), .sy(in_src_y), .dx(in_dst_x), .dy(in_dst_y),
    .r0ab(r0ab_r), .r1ab(r1ab_r), .r2ab(r2ab_r),
    .r0c(r0c_r), .r1c(r1c_r), .r2c(r2c_r),
    .v_o(v_mac), .s_o(s_mac)
  );

  // Two restoring dividers share the |w| divisor; quotient carries one
  // extra bit for round-half-away.
  hre_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v_mac), .s_i(s_mac),
    .v_o(v_div), .d_o(d_div)
  );

  hre_err u_err (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v_div), .d_i(d_div),
    .v_o(out_valid), .px_o(out_proj_x), .py_o(out_proj_y),
    .err_o(out_sq_error), .wz_o(out_w_zero)
  );
endmodule
`default_nettype wire

// File: tb/tb.sv
module tb;

  localparam int LATENCY   = 41;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 480;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_src_x = '0, in_src_y = '0, in_dst_x = '0, in_dst_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_proj_x, out_proj_y;
  logic [63:0] out_sq_error;
  logic out_w_zero;
  logic cfg_we = 1'b0;
  logic [hre_pkg::RIW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  homography_reprojection_error u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_src_x(in_src_x), .in_src_y(in_src_y),
    .in_dst_x(in_dst_x), .in_dst_y(in_dst_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_proj_x(out_proj_x), .out_proj_y(out_proj_y),
    .out_sq_error(out_sq_error), .out_w_zero(out_w_zero),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [63:0] err;
    logic wz;
  } reproj_t;

  // local copy of the homography, Q16.16 coefficients
  logic signed [31:0] hm [0:8];
  reproj_t reproj_q[$];

  int errors = 0;
  int cycle = 0;
  int n_sent = 0, n_recv = 0, n_wzero = 0, n_sat = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int recv_hold = 0;   // cycles the receiver still holds off

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle);
      $display("FAIL");
      $finish;
    end
  end

  function automatic void hom_reset();
    foreach (hm[i]) hm[i] = '0;
    hm[0] = 32'sd65536;
    hm[4] = 32'sd65536;
    hm[8] = 32'sd65536;
  endfunction

  // mirror of a register write into the local matrix
  function automatic void hom_write(input logic [hre_pkg::RIW-1:0] idx,
                                    input logic [63:0] v);
    case (idx)
      hre_pkg::REG_ROW0_AB: begin hm[0] = v[31:0]; hm[1] = v[63:32]; end
      hre_pkg::REG_ROW0_C:  hm[2] = v[31:0];
      hre_pkg::REG_ROW1_AB: begin hm[3] = v[31:0]; hm[4] = v[63:32]; end
      hre_pkg::REG_ROW1_C:  hm[5] = v[31:0];
      hre_pkg::REG_ROW2_AB: begin hm[6] = v[31:0]; hm[7] = v[63:32]; end
      hre_pkg::REG_ROW2_C:  hm[8] = v[31:0];
      default: ;
    endcase
  endfunction

  // num * 2^16 / den, rounded half away from zero, saturated to 32 bits
  function automatic logic signed [31:0] persp_div(input logic signed [127:0] num,
                                                   input logic signed [127:0] den);
    logic [127:0] n, d, q, r;
    logic neg;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    n = n << hre_pkg::FRAC_BITS;
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    if (!neg) return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    if (q > 128'h8000_0000) return 32'sh8000_0000;
    return -q[31:0];
  endfunction

  function automatic reproj_t reproject(input logic signed [31:0] sx, sy, dx, dy);
    reproj_t e;
    logic signed [127:0] X, Y, W, one;
    logic signed [33:0] ddx, ddy;
    logic [63:0] sqx, sqy;
    logic [64:0] s;
    one = 128'sd1 <<< hre_pkg::FRAC_BITS;
    X = 128'(hm[0]) * 128'(sx) + 128'(hm[1]) * 128'(sy) + 128'(hm[2]) * one;
    Y = 128'(hm[3]) * 128'(sx) + 128'(hm[4]) * 128'(sy) + 128'(hm[5]) * one;
    W = 128'(hm[6]) * 128'(sx) + 128'(hm[7]) * 128'(sy) + 128'(hm[8]) * one;
    if (W == 0) begin
      e.px = '0; e.py = '0; e.err = '1; e.wz = 1'b1;
      return e;
    end
    e.px = persp_div(X, W);
    e.py = persp_div(Y, W);
    e.wz = 1'b0;
    ddx = 34'(dx) - 34'(e.px);
    ddy = 34'(dy) - 34'(e.py);
    sqx = 64'(ddx * ddx);
    sqy = 64'(ddy * ddy);
    s = {1'b0, sqx} + {1'b0, sqy};
    e.err = s[64] ? '1 : s[63:0];
    return e;
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    reproj_t e;
    if (rst_n && out_valid && out_ready) begin
      n_recv <= n_recv + 1;
      if (reproj_q.size() == 0) begin
        $error("unexpected result beat: proj_x %0d proj_y %0d", out_proj_x, out_proj_y);
        errors <= errors + 1;
      end else begin
        e = reproj_q.pop_front();
        if (out_proj_x !== e.px) begin
          $error("proj_x exp %0d got %0d", e.px, out_proj_x); errors <= errors + 1;
        end
        if (out_proj_y !== e.py) begin
          $error("proj_y exp %0d got %0d", e.py, out_proj_y); errors <= errors + 1;
        end
        if (out_sq_error !== e.err) begin
          $error("sq_error exp %h got %h", e.err, out_sq_error); errors <= errors + 1;
        end
        if (out_w_zero !== e.wz) begin
          $error("w_zero exp %b got %b", e.wz, out_w_zero); errors <= errors + 1;
        end
      end
    end
  end

  // one beat on the input channel; valid held until accepted, dropped only
  // when the sender idles or stops
  task automatic send_pair(input logic signed [31:0] sx, sy, dx, dy);
    reproj_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_x <= sx; in_src_y <= sy; in_dst_x <= dx; in_dst_y <= dy;
    e = reproject(sx, sy, dx, dy);
    if (e.wz) n_wzero++;
    if (!e.wz && (e.px == 32'sh7FFF_FFFF || e.px == 32'sh8000_0000)) n_sat++;
    reproj_q.insert(reproj_q.size(), e);
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // expected value typed in: check it against the predictor too
  task automatic send_known(input logic signed [31:0] sx, sy, dx, dy,
                            input logic signed [31:0] px, py,
                            input logic [63:0] err, input logic wz);
    reproj_t e;
    e = reproject(sx, sy, dx, dy);
    if (e.px !== px || e.py !== py || e.err !== err || e.wz !== wz) begin
      $error("table row disagrees: proj_x exp %0d got %0d, sq_error exp %h got %h",
             px, e.px, err, e.err);
      errors++;
    end
    send_pair(sx, sy, dx, dy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (reproj_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // matrix writes only with the pipe empty
  task automatic cfg_write(input logic [hre_pkg::RIW-1:0] idx, input logic [63:0] v);
    in_valid <= 1'b0;
    while (reproj_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hom_write(idx, v);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
      3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 2000)) - 32'sd1000;
    endcase
  endfunction

  function automatic logic [31:0] rnd_coef();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 64)) - 32'sd32;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [63:0] rnd_pair();
    return {rnd_coef(), rnd_coef()};
  endfunction

  typedef struct {
    logic signed [31:0] sx, sy, dx, dy, px, py;
    logic [63:0] err;
    logic wz;
  } pair_row_t;

  // identity homography: projection is the source point itself
  pair_row_t dir_tab [6] = '{
    '{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000,
      32'sh0001_0000, 32'sh0002_0000, 64'd0, 1'b0},
    '{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 64'h1_0000_0000, 1'b0},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
      32'sh7FFF_FFFF, 32'sh8000_0000, 64'd0, 1'b0},
    // worst distances: both axes opposite extremes, sum overflows
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{32'sh8000_0000, 32'sh0, 32'sh7FFF_FFFF, 32'sh0,
      32'sh8000_0000, 32'sh0, 64'hFFFF_FFFE_0000_0001, 1'b0},
    '{32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0, 32'sh0,
      32'shFFFF_FFFF, 32'sh0000_0001, 64'd2, 1'b0}
  };

  int k;

  initial begin
    hom_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity after reset, typed-in results
    foreach (dir_tab[i])
      send_known(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].dx, dir_tab[i].dy,
                 dir_tab[i].px, dir_tab[i].py, dir_tab[i].err, dir_tab[i].wz);
    drain();

    // w forced to zero: flag, zero projection, max error
    cfg_write(hre_pkg::REG_ROW2_C, 64'h0);
    send_known(32'sh0, 32'sh0, 32'sh1234_5678, 32'sh8000_0000,
               32'sh0, 32'sh0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // out-of-range index leaves H untouched
    cfg_write(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    // w = x (h20 = 1): zero at x = 0, nonzero elsewhere
    cfg_write(hre_pkg::REG_ROW2_AB, 64'h0000_0000_0001_0000);
    send_pair(32'sh0, 32'sh0005_0000, 32'sh0, 32'sh0);
    send_pair(32'sh0003_0000, 32'sh0001_0000, 32'sh0, 32'sh0);
    send_pair(32'shFFFD_0000, 32'sh0001_0000, 32'sh0, 32'sh0);
    // tiny w, projection saturates both ways; rounding ties
    cfg_write(hre_pkg::REG_ROW2_AB, 64'h0);
    cfg_write(hre_pkg::REG_ROW2_C, 64'h0000_0000_0000_0001);
    send_pair(32'sh0001_0000, 32'shFFFF_0000, 32'sh0, 32'sh0);
    cfg_write(hre_pkg::REG_ROW2_C, 64'h0000_0000_0002_0000);
    send_pair(32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0, 32'sh0);
    send_pair(32'sh0000_0003, 32'shFFFF_FFFD, 32'sh0, 32'sh0);
    // extreme coefficients in every register, high bits set in the row 0 and row 2 c registers
    cfg_write(hre_pkg::REG_ROW0_AB, 64'h8000_0000_7FFF_FFFF);
    cfg_write(hre_pkg::REG_ROW0_C,  64'hFFFF_FFFF_8000_0000);
    cfg_write(hre_pkg::REG_ROW1_AB, 64'h7FFF_FFFF_8000_0000);
    cfg_write(hre_pkg::REG_ROW1_C,  64'h0000_0000_7FFF_FFFF);
    cfg_write(hre_pkg::REG_ROW2_AB, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(hre_pkg::REG_ROW2_C,  64'h8000_0000_8000_0000);
    send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'shFFFF_FFFF);
    send_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_pair(32'sh0, 32'sh0, 32'sh0, 32'sh0);
    drain();

    // random: three idle profiles, fresh matrix per phase
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph % 3 == 0) ? 24 : (ph % 3 == 1) ? 65 : 0;
      recv_idle_pct = (ph % 3 == 0) ? 65 : (ph % 3 == 1) ? 24 : 0;
      if (ph == 0) begin
        cfg_write(hre_pkg::REG_ROW0_AB, 64'h0000_0000_0001_0000);
        cfg_write(hre_pkg::REG_ROW0_C, 64'h0);
        cfg_write(hre_pkg::REG_ROW1_AB, 64'h0001_0000_0000_0000);
        cfg_write(hre_pkg::REG_ROW1_C, 64'h0);
        cfg_write(hre_pkg::REG_ROW2_AB, 64'h0);
        cfg_write(hre_pkg::REG_ROW2_C, 64'h0000_0000_0001_0000);
      end else begin
        cfg_write(hre_pkg::REG_ROW0_AB, rnd_pair());
        cfg_write(hre_pkg::REG_ROW0_C, {$urandom, rnd_coef()});
        cfg_write(hre_pkg::REG_ROW1_AB, rnd_pair());
        cfg_write(hre_pkg::REG_ROW1_C, {$urandom, rnd_coef()});
        cfg_write(hre_pkg::REG_ROW2_AB, rnd_pair());
        cfg_write(hre_pkg::REG_ROW2_C, {$urandom, rnd_coef()});
      end
      for (k = 0; k < N_RANDOM / 6; k++) begin
        // long receiver hold-off mid-phase so the pipe backs up into the input
        if (ph == 2 && k == 10) recv_hold = 3 * LATENCY;
        // sender waits for the pipe to empty once
        if (ph == 4 && k == 40) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (reproj_q.size() != 0);
        end
        send_pair(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      end
      drain();
    end

    $display("%0d pairs sent, %0d results checked; %0d with w zero, %0d saturated x",
             n_sent, n_recv, n_wzero, n_sat);
    $display("matrix settings: identity, zero/tiny w, extremes, 5 random");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
